// ===== rtl/irtok_pkg.sv =====
// Shared types and constants for the IR text tokenizer.
`default_nettype none
package irtok_pkg;

  localparam int PosBits = 20;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  typedef logic [PosBits-1:0] pos_t;
  // Bit 8 set marks the end of input.
  typedef logic [8:0] char_t;
  localparam char_t EndMark = 9'h100;

  localparam logic [5:0] KEof     = 6'd0;
  localparam logic [5:0] KInvalid = 6'd1;
  localparam logic [5:0] KIdent   = 6'd25;
  localparam logic [5:0] KValue   = 6'd26;
  localparam logic [5:0] KSymbol  = 6'd27;
  localparam logic [5:0] KInt     = 6'd28;
  localparam logic [5:0] KFloat   = 6'd29;
  localparam logic [5:0] KString  = 6'd30;
  localparam logic [5:0] KArrow   = 6'd39;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [5:0]         token_kind;
    pos_t               start_line;
    pos_t               start_column;
    pos_t               token_length;
    logic signed [63:0] int_value;
    logic               last;
  } out_t;

  // Character queue between front and back.
  typedef struct packed {
    logic  valid;
    char_t ch;
  } cq_t;

endpackage
`default_nettype wire

// ===== rtl/irtok_front.sv =====
// Input front: accepts beats, maps the end flag to a character code, queues them.
`default_nettype none
module irtok_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire irtok_pkg::in_t  in_data_i,
  output irtok_pkg::cq_t       cq_o,
  input  wire logic            cq_ready_i
);

  irtok_pkg::char_t mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;
  irtok_pkg::char_t ch;

  assign ch = in_data_i.kind ? irtok_pkg::EndMark : {1'b0, in_data_i.byte_value};
  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = cq_o.valid && cq_ready_i;
  assign cq_o.valid = (cnt_q != 2'd0);
  assign cq_o.ch = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= ch;
  end

endmodule
`default_nettype wire

// ===== rtl/irtok_back.sv =====
// Scanner back end: work stack, lookahead, token state and output staging.
`default_nettype none
module irtok_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire irtok_pkg::cq_t  cq_i,
  output logic                 cq_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output irtok_pkg::out_t      out_data_o
);

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_SLASH, M_MINUS, M_MINUS_I, M_MINUS_IN, M_MINUS_N,
    M_MINUS_NA, M_MINUS_DOT, M_INF_TAIL, M_VALUE, M_SYMBOL, M_WORD, M_STRING,
    M_STRING_ESC, M_NUM_ZERO, M_NUM_DEC, M_NUM_DEC_EXP, M_NUM_HEX, M_NUM_HEX_EXP
  } mode_e;

  typedef struct packed {
    irtok_pkg::pos_t line;
    irtok_pkg::pos_t col;
    irtok_pkg::pos_t len;
  } cursor_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [4:0]  len;
    logic [95:0] text;
  } kw_t;

  localparam int KwChars = 12;
  localparam int LaDepth = 16;
  localparam int StackDepth = LaDepth + 2;
  localparam int KwNum = 26;
  localparam logic [63:0] MagLimit = 64'h8000_0000_0000_0000;

  localparam kw_t KwTable [KwNum] = '{
    '{6'd29, 5'd3, 96'("nan")}, '{6'd29, 5'd3, 96'("inf")},
    '{6'd29, 5'd8, 96'("infinity")}, '{6'd2, 5'd4, 96'("func")},
    '{6'd3, 5'd6, 96'("extern")}, '{6'd4, 5'd6, 96'("module")},
    '{6'd5, 5'd12, 96'("resume_table")}, '{6'd6, 5'd5, 96'("entry")},
    '{6'd7, 5'd3, 96'("ret")}, '{6'd8, 5'd2, 96'("br")},
    '{6'd9, 5'd5, 96'("br_if")}, '{6'd10, 5'd5, 96'("guard")},
    '{6'd11, 5'd12, 96'("resume_point")}, '{6'd12, 5'd9, 96'("safepoint")},
    '{6'd13, 5'd11, 96'("unreachable")}, '{6'd14, 5'd3, 96'("i32")},
    '{6'd15, 5'd3, 96'("i64")}, '{6'd16, 5'd3, 96'("f32")},
    '{6'd17, 5'd3, 96'("f64")}, '{6'd18, 5'd3, 96'("ptr")},
    '{6'd19, 5'd5, 96'("gcref")}, '{6'd20, 5'd4, 96'("void")},
    '{6'd21, 5'd5, 96'("f32x4")}, '{6'd22, 5'd5, 96'("f64x2")},
    '{6'd23, 5'd5, 96'("i32x4")}, '{6'd24, 5'd5, 96'("i64x2")}
  };

  localparam logic [39:0] InfTail = "inity";

  function automatic logic isc(irtok_pkg::char_t c, logic [7:0] x);
    return !c[8] && (c[7:0] == x);
  endfunction

  function automatic logic is_digit(irtok_pkg::char_t c);
    return !c[8] && c[7:0] >= "0" && c[7:0] <= "9";
  endfunction

  function automatic logic is_alpha(irtok_pkg::char_t c);
    return !c[8] && ((c[7:0] >= "a" && c[7:0] <= "z") || (c[7:0] >= "A" && c[7:0] <= "Z"));
  endfunction

  function automatic logic is_word(irtok_pkg::char_t c);
    return is_alpha(c) || is_digit(c) || isc(c, "_") || isc(c, ".");
  endfunction

  function automatic logic [4:0] hex_val(irtok_pkg::char_t c);
    logic [4:0] r;
    r = 5'd16;
    if (is_digit(c)) r = 5'(c[7:0] - 8'h30);
    else if (!c[8] && c[7:0] >= "a" && c[7:0] <= "f") r = 5'(c[7:0] - 8'h57);
    else if (!c[8] && c[7:0] >= "A" && c[7:0] <= "F") r = 5'(c[7:0] - 8'h37);
    return r;
  endfunction

  function automatic logic [5:0] punct(irtok_pkg::char_t c);
    logic [5:0] k;
    k = 6'd0;
    if (!c[8]) begin
      case (c[7:0])
        "(": k = 6'd31;
        ")": k = 6'd32;
        "{": k = 6'd33;
        "}": k = 6'd34;
        "[": k = 6'd35;
        "]": k = 6'd36;
        ",": k = 6'd37;
        ":": k = 6'd38;
        "=": k = 6'd40;
        default: k = 6'd0;
      endcase
    end
    return k;
  endfunction

  function automatic irtok_pkg::pos_t sat_add(irtok_pkg::pos_t a, logic [4:0] n);
    logic [irtok_pkg::PosBits:0] s;
    s = {1'b0, a} + (irtok_pkg::PosBits+1)'(n);
    return (s > (irtok_pkg::PosBits+1)'(irtok_pkg::PosMax)) ? irtok_pkg::PosMax
                                                            : s[irtok_pkg::PosBits-1:0];
  endfunction

  // Advance the cursor by n non-LF characters, or by one LF; optionally count length.
  function automatic cursor_t adv(cursor_t p, logic lf, logic [4:0] n, logic tk);
    cursor_t r;
    r = p;
    if (lf) begin
      r.line = sat_add(p.line, 5'd1);
      r.col = irtok_pkg::pos_t'(1);
    end else begin
      r.col = sat_add(p.col, n);
    end
    if (tk) r.len = sat_add(p.len, n);
    return r;
  endfunction

  // Returns {over, acc}.
  function automatic logic [64:0] accum(logic [63:0] acc, logic over, logic [3:0] d,
                                        logic hex);
    logic [67:0] prod, sum;
    logic [64:0] r;
    r = {over, acc};
    if (!over) begin
      prod = hex ? {acc, 4'b0} : ({1'b0, acc, 3'b0} + {3'b0, acc, 1'b0});
      sum = prod + 68'(d);
      if (sum > 68'(MagLimit)) r = {1'b1, MagLimit};
      else r = {1'b0, sum[63:0]};
    end
    return r;
  endfunction

  function automatic logic [5:0] classify(logic [7:0] w [KwChars], logic [4:0] n);
    logic [5:0] k;
    logic       found, m;
    int         idx;
    k = irtok_pkg::KIdent;
    found = 1'b0;
    for (int e = 0; e < KwNum; e++) begin
      m = (n == KwTable[e].len);
      for (int i = 0; i < KwChars; i++) begin
        idx = int'(KwTable[e].len) - 1 - i;
        if (i < int'(KwTable[e].len) && w[i] != KwTable[e].text[8*idx +: 8]) m = 1'b0;
      end
      if (m && !found) begin
        k = KwTable[e].kind;
        found = 1'b1;
      end
    end
    return k;
  endfunction

  mode_e            mode_q, mode_d;
  logic [7:0]       la_q [LaDepth];
  logic [7:0]       la_d [LaDepth];
  logic [4:0]       lacnt_q, lacnt_d;
  logic [7:0]       word_q [KwChars];
  logic [7:0]       word_d [KwChars];
  logic [4:0]       wcnt_q, wcnt_d;
  cursor_t          cur_q, cur_d;
  irtok_pkg::pos_t  tline_q, tline_d, tcol_q, tcol_d;
  logic [63:0]      acc_q, acc_d;
  logic             fneg_q, fneg_d, ffloat_q, ffloat_d, fover_q, fover_d;
  irtok_pkg::char_t stk_q [StackDepth];
  irtok_pkg::char_t stk_d [StackDepth];
  logic [4:0]       top_q, top_d;
  logic             rep_q, rep_d;
  logic [4:0]       ridx_q, ridx_d;
  logic             rfrom_q, rfrom_d;
  irtok_pkg::out_t  pend_q, pend_d, out_q, out_d;
  logic             pend_v_q, pend_v_d, out_v_q, out_v_d;

  irtok_pkg::char_t c;
  logic             out_free, emit_v, emit_eof;
  logic [5:0]       emit_kind;
  logic [63:0]      emit_val;
  logic [64:0]      acc_r;
  logic [4:0]       hv;
  logic [5:0]       pk;
  logic [7:0]       tail_ch;
  logic             rfrom;
  irtok_pkg::out_t  tok;

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    mode_d = mode_q;
    la_d = la_q;
    lacnt_d = lacnt_q;
    word_d = word_q;
    wcnt_d = wcnt_q;
    cur_d = cur_q;
    tline_d = tline_q;
    tcol_d = tcol_q;
    acc_d = acc_q;
    fneg_d = fneg_q;
    ffloat_d = ffloat_q;
    fover_d = fover_q;
    stk_d = stk_q;
    top_d = top_q;
    rep_d = rep_q;
    ridx_d = ridx_q;
    rfrom_d = rfrom_q;
    pend_d = pend_q;
    pend_v_d = pend_v_q;
    out_d = out_q;
    out_v_d = out_v_q && !out_ready_i;
    cq_ready_o = 1'b0;
    emit_v = 1'b0;
    emit_eof = 1'b0;
    emit_kind = irtok_pkg::KEof;
    emit_val = 64'd0;
    c = stk_q[top_q - 5'd1];
    acc_r = '0;
    hv = '0;
    pk = '0;
    tail_ch = '0;
    rfrom = 1'b0;
    tok = '0;

    if (rep_q) begin
      // Push held bytes back, newest first, so the oldest is scanned first.
      if (top_d < 5'(StackDepth)) begin
        stk_d[top_d] = {1'b0, la_q[4'(ridx_q - 5'd1)]};
        top_d = top_d + 5'd1;
      end
      ridx_d = ridx_q - 5'd1;
      if (ridx_d == 5'(rfrom_q)) rep_d = 1'b0;
    end else if (top_q != 5'd0) begin
      if (!pend_v_q || out_free) begin
        top_d = top_q - 5'd1;
        // Each arm handles one scan mode or a group of modes; a push re-queues c for rescanning.
        case (mode_q)
          M_COMMENT: begin
            if (isc(c, 8'h0A) || c[8]) begin
              mode_d = M_IDLE;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end else cur_d = adv(cur_d, 1'b0, 5'd1, 1'b0);
          end
          M_SLASH: begin
            cur_d = adv(cur_d, 1'b0, lacnt_d, 1'b1);
            lacnt_d = '0;
            if (isc(c, "/")) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              mode_d = M_COMMENT;
            end else begin
              emit_v = 1'b1; emit_kind = irtok_pkg::KInvalid;
              mode_d = M_IDLE;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end
          end
          M_MINUS, M_MINUS_I, M_MINUS_IN, M_MINUS_N, M_MINUS_NA, M_MINUS_DOT: begin
            rfrom = 1'b0;
            if (mode_q == M_MINUS && isc(c, ">")) begin
              cur_d = adv(cur_d, 1'b0, lacnt_d + 5'd1, 1'b1);
              lacnt_d = '0;
              emit_v = 1'b1; emit_kind = irtok_pkg::KArrow;
              mode_d = M_IDLE;
            end else if (mode_q == M_MINUS && is_digit(c)) begin
              cur_d = adv(cur_d, 1'b0, lacnt_d + 5'd1, 1'b1);
              lacnt_d = '0;
              fneg_d = 1'b1;
              acc_r = accum(acc_d, fover_d, 4'(c[7:0] - 8'h30), 1'b0);
              fover_d = acc_r[64]; acc_d = acc_r[63:0];
              mode_d = isc(c, "0") ? M_NUM_ZERO : M_NUM_DEC;
            end else if ((mode_q == M_MINUS && (isc(c, "i") || isc(c, "n") || isc(c, ".")))
                         || (mode_q == M_MINUS_I && isc(c, "n"))
                         || (mode_q == M_MINUS_N && isc(c, "a"))) begin
              if (lacnt_d < 5'(LaDepth)) begin
                la_d[4'(lacnt_d)] = c[7:0]; lacnt_d = lacnt_d + 5'd1;
              end
              if (mode_q == M_MINUS_I) mode_d = M_MINUS_IN;
              else if (mode_q == M_MINUS_N) mode_d = M_MINUS_NA;
              else if (isc(c, "i")) mode_d = M_MINUS_I;
              else if (isc(c, "n")) mode_d = M_MINUS_N;
              else mode_d = M_MINUS_DOT;
            end else if (mode_q == M_MINUS_IN && isc(c, "f")) begin
              cur_d = adv(cur_d, 1'b0, lacnt_d + 5'd1, 1'b1);
              lacnt_d = '0;
              mode_d = M_INF_TAIL;
            end else if (mode_q == M_MINUS_NA && isc(c, "n")) begin
              cur_d = adv(cur_d, 1'b0, lacnt_d + 5'd1, 1'b1);
              lacnt_d = '0;
              emit_v = 1'b1; emit_kind = irtok_pkg::KFloat;
              mode_d = M_IDLE;
            end else if (mode_q == M_MINUS_DOT && is_digit(c)) begin
              cur_d = adv(cur_d, 1'b0, lacnt_d, 1'b1);
              lacnt_d = '0;
              fneg_d = 1'b1; ffloat_d = 1'b1;
              mode_d = M_NUM_DEC;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end else begin
              // Failed match: the minus alone is invalid, rescan the rest.
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              emit_v = 1'b1; emit_kind = irtok_pkg::KInvalid;
              mode_d = M_IDLE;
              rfrom = 1'b1;
              if (top_d < 5'(StackDepth)) begin
                stk_d[top_d] = c; top_d = top_d + 5'd1;
              end
              if (lacnt_d > 5'd1) begin
                rep_d = 1'b1; ridx_d = lacnt_d; rfrom_d = rfrom;
              end
              lacnt_d = '0;
            end
          end
          M_INF_TAIL: begin
            case (lacnt_d)
              5'd0: tail_ch = InfTail[39:32];
              5'd1: tail_ch = InfTail[31:24];
              5'd2: tail_ch = InfTail[23:16];
              5'd3: tail_ch = InfTail[15:8];
              default: tail_ch = InfTail[7:0];
            endcase
            if (lacnt_d < 5'd5 && isc(c, tail_ch)) begin
              if (lacnt_d == 5'd4) begin
                cur_d = adv(cur_d, 1'b0, lacnt_d + 5'd1, 1'b1);
                lacnt_d = '0;
                emit_v = 1'b1; emit_kind = irtok_pkg::KFloat;
                mode_d = M_IDLE;
              end else begin
                la_d[4'(lacnt_d)] = c[7:0]; lacnt_d = lacnt_d + 5'd1;
              end
            end else begin
              emit_v = 1'b1; emit_kind = irtok_pkg::KFloat;
              mode_d = M_IDLE;
              if (top_d < 5'(StackDepth)) begin
                stk_d[top_d] = c; top_d = top_d + 5'd1;
              end
              if (lacnt_d > 5'd0) begin
                rep_d = 1'b1; ridx_d = lacnt_d; rfrom_d = 1'b0;
              end
              lacnt_d = '0;
            end
          end
          M_VALUE, M_SYMBOL: begin
            if (is_word(c) || (mode_q == M_SYMBOL && isc(c, "-"))) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
            end else begin
              emit_v = 1'b1;
              emit_kind = (mode_q == M_VALUE) ? irtok_pkg::KValue : irtok_pkg::KSymbol;
              mode_d = M_IDLE;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end
          end
          M_WORD: begin
            if (is_word(c)) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              if (wcnt_d < 5'(KwChars)) word_d[4'(wcnt_d)] = c[7:0];
              if (wcnt_d <= 5'(KwChars)) wcnt_d = wcnt_d + 5'd1;
            end else begin
              emit_v = 1'b1;
              emit_kind = (wcnt_q > 5'(KwChars)) ? irtok_pkg::KIdent : classify(word_q, wcnt_q);
              mode_d = M_IDLE;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end
          end
          M_STRING, M_STRING_ESC: begin
            if (c[8]) begin
              emit_v = 1'b1; emit_kind = irtok_pkg::KString;
              mode_d = M_IDLE;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end else if (mode_q == M_STRING && isc(c, 8'h22)) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              emit_v = 1'b1; emit_kind = irtok_pkg::KString;
              mode_d = M_IDLE;
            end else begin
              cur_d = adv(cur_d, isc(c, 8'h0A), 5'd1, 1'b1);
              if (mode_q == M_STRING_ESC) mode_d = M_STRING;
              else if (isc(c, 8'h5C)) mode_d = M_STRING_ESC;
            end
          end
          M_NUM_ZERO: begin
            if (isc(c, "x") || isc(c, "X")) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              mode_d = M_NUM_HEX;
            end else begin
              mode_d = M_NUM_DEC;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end
          end
          M_NUM_DEC, M_NUM_HEX: begin
            hv = hex_val(c);
            if ((mode_q == M_NUM_DEC && is_digit(c)) || (mode_q == M_NUM_HEX && hv < 5'd16))
            begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              acc_r = accum(acc_d, fover_d, hv[3:0], mode_q == M_NUM_HEX);
              fover_d = acc_r[64]; acc_d = acc_r[63:0];
            end else if (isc(c, ".")) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              ffloat_d = 1'b1;
            end else if (mode_q == M_NUM_DEC && (isc(c, "e") || isc(c, "E"))) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              ffloat_d = 1'b1; mode_d = M_NUM_DEC_EXP;
            end else if (mode_q == M_NUM_HEX && (isc(c, "p") || isc(c, "P"))) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
              ffloat_d = 1'b1; mode_d = M_NUM_HEX_EXP;
            end else begin
              emit_v = 1'b1;
              if (ffloat_q) emit_kind = irtok_pkg::KFloat;
              else begin
                emit_kind = irtok_pkg::KInt;
                if (fneg_q) emit_val = fover_q ? MagLimit : (64'd0 - acc_q);
                else emit_val = (fover_q || acc_q > MagLimit - 64'd1) ? MagLimit - 64'd1
                                                                      : acc_q;
              end
              mode_d = M_IDLE;
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end
          end
          M_NUM_DEC_EXP, M_NUM_HEX_EXP: begin
            if (isc(c, "+") || isc(c, "-")) cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
            else begin
              stk_d[top_d] = c; top_d = top_d + 5'd1;
            end
            mode_d = (mode_q == M_NUM_DEC_EXP) ? M_NUM_DEC : M_NUM_HEX;
          end
          default: begin
            mode_d = M_IDLE;
            pk = punct(c);
            if (c[8]) begin
              emit_v = 1'b1; emit_eof = 1'b1; emit_kind = irtok_pkg::KEof;
              lacnt_d = '0; wcnt_d = '0;
              cur_d.line = irtok_pkg::pos_t'(1);
              cur_d.col = irtok_pkg::pos_t'(1);
              cur_d.len = '0;
              tline_d = irtok_pkg::pos_t'(1);
              tcol_d = irtok_pkg::pos_t'(1);
              acc_d = '0; fneg_d = 1'b0; ffloat_d = 1'b0; fover_d = 1'b0;
            end else if (isc(c, " ") || isc(c, 8'h09) || isc(c, 8'h0D) || isc(c, 8'h0A)) begin
              cur_d = adv(cur_d, isc(c, 8'h0A), 5'd1, 1'b0);
            end else if (isc(c, ";")) begin
              cur_d = adv(cur_d, 1'b0, 5'd1, 1'b0);
              mode_d = M_COMMENT;
            end else begin
              // Open a new token here.
              tline_d = cur_d.line; tcol_d = cur_d.col; cur_d.len = '0;
              acc_d = '0; fneg_d = 1'b0; ffloat_d = 1'b0; fover_d = 1'b0;
              wcnt_d = '0; lacnt_d = '0;
              if (pk != 6'd0) begin
                cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
                emit_v = 1'b1; emit_kind = pk;
              end else if (isc(c, "/") || isc(c, "-")) begin
                la_d[0] = c[7:0]; lacnt_d = 5'd1;
                mode_d = isc(c, "/") ? M_SLASH : M_MINUS;
              end else if (isc(c, "%") || isc(c, "@") || isc(c, 8'h22)) begin
                cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
                mode_d = isc(c, "%") ? M_VALUE : (isc(c, "@") ? M_SYMBOL : M_STRING);
              end else if (is_digit(c)) begin
                cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
                acc_r = accum(64'd0, 1'b0, 4'(c[7:0] - 8'h30), 1'b0);
                fover_d = acc_r[64]; acc_d = acc_r[63:0];
                mode_d = isc(c, "0") ? M_NUM_ZERO : M_NUM_DEC;
              end else if (is_alpha(c) || isc(c, "_")) begin
                cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
                word_d[0] = c[7:0]; wcnt_d = 5'd1;
                mode_d = M_WORD;
              end else begin
                cur_d = adv(cur_d, 1'b0, 5'd1, 1'b1);
                emit_v = 1'b1; emit_kind = irtok_pkg::KInvalid;
              end
            end
          end
        endcase

        if (emit_v) begin
          tok.token_kind = emit_kind;
          tok.start_line = emit_eof ? cur_q.line : tline_d;
          tok.start_column = emit_eof ? cur_q.col : tcol_d;
          tok.token_length = emit_eof ? '0 : cur_d.len;
          tok.int_value = emit_val;
          tok.last = 1'b0;
          if (pend_v_q) begin
            out_d = pend_q; out_v_d = 1'b1;
          end
          pend_d = tok; pend_v_d = 1'b1;
        end
      end
    end else begin
      // Step done: release the held token as the last one, take the next character.
      if (!pend_v_q || out_free) begin
        if (pend_v_q) begin
          out_d = pend_q; out_d.last = 1'b1; out_v_d = 1'b1;
          pend_v_d = 1'b0;
        end
        cq_ready_o = 1'b1;
        if (cq_i.valid) begin
          stk_d[0] = cq_i.ch;
          top_d = 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      lacnt_q <= '0;
      wcnt_q <= '0;
      cur_q <= '{line: irtok_pkg::pos_t'(1), col: irtok_pkg::pos_t'(1), len: '0};
      tline_q <= irtok_pkg::pos_t'(1);
      tcol_q <= irtok_pkg::pos_t'(1);
      acc_q <= '0;
      fneg_q <= 1'b0;
      ffloat_q <= 1'b0;
      fover_q <= 1'b0;
      top_q <= '0;
      rep_q <= 1'b0;
      ridx_q <= '0;
      rfrom_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      lacnt_q <= lacnt_d;
      wcnt_q <= wcnt_d;
      cur_q <= cur_d;
      tline_q <= tline_d;
      tcol_q <= tcol_d;
      acc_q <= acc_d;
      fneg_q <= fneg_d;
      ffloat_q <= ffloat_d;
      fover_q <= fover_d;
      top_q <= top_d;
      rep_q <= rep_d;
      ridx_q <= ridx_d;
      rfrom_q <= rfrom_d;
      pend_v_q <= pend_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q <= la_d;
    word_q <= word_d;
    stk_q <= stk_d;
    pend_q <= pend_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire

// ===== rtl/ir_text_tokenizer_top.sv =====
// Top level of the IR text tokenizer: front queue plus scanner back end.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_data_i  (irtok_pkg::in_t)
//   out      output     out_valid_o/out_ready_i out_data_o (irtok_pkg::out_t)
//
// The scanner first scans a plain byte, then closes the beat and loads the next
// byte. Every byte pushed back for rescanning is scanned again, as are the held
// bytes that a failed lookahead re-queues.
// Reset puts the scanner between tokens at line 1, column 1.
// A stalled output holds the scanner once a second token is ready; the
// two-entry input queue keeps accepting meanwhile until it is full.
`default_nettype none
module ir_text_tokenizer_top (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire irtok_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output irtok_pkg::out_t      out_data_o
);

  irtok_pkg::cq_t cq;
  logic           cq_ready;

  irtok_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cq_o       (cq),
    .cq_ready_i (cq_ready)
  );

  irtok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cq_i        (cq),
    .cq_ready_o  (cq_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
